// ----- rtl/fbw_pkg.sv -----
// Shared types, constants and colour conversion functions for the framebuffer word converter.
package fbw_pkg;

	// Fixed field widths.
	localparam int WORD_W  = 32;
	localparam int COLOR_W = 16;
	localparam int PX_W    = 11;
	localparam int RIGHT_W = 12;
	localparam int DEPTH_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// One lane per pixel at the finest depth.
	localparam int LANES   = 32;
	localparam int LANE_IW = $clog2(LANES);

	// Column arithmetic: first column plus lane index, and the line-length compare.
	localparam int XW    = 12;
	localparam int LIM_W = 13;

	localparam int MAX_LINE_PIXELS_DEF = 2048;

	// Depth codes.
	localparam logic [DEPTH_W-1:0] DEPTH_1  = 2'd0;
	localparam logic [DEPTH_W-1:0] DEPTH_8  = 2'd1;
	localparam logic [DEPTH_W-1:0] DEPTH_16 = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 2'd2;

	localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;
	localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;

	// What one lane found for its pixel.
	typedef struct packed {
		logic               valid;
		logic [COLOR_W-1:0] color;
	} lane_res_t;

	// RGB332 to RGB565: each component lands at the top of its field.
	function automatic logic [COLOR_W-1:0] expand_332(input logic [7:0] v);
		return {v[7:5], 2'b00, v[4:2], 3'b000, v[1:0], 3'b000};
	endfunction

	// RGB555 to RGB565 with green moved up one place; the top bit is dropped.
	function automatic logic [COLOR_W-1:0] remap_555(input logic [15:0] v);
		return {v[14:10], v[9:5], 1'b0, v[4:0]};
	endfunction

endpackage

// ----- rtl/framebuffer_word_to_rgb565.sv -----
// Top level: configuration registers, 32 pixel lanes and the merging stage.
// An accepted item is registered in fbw_merge, and its pixels in the output register.
// Throughput: one pixel per cycle from a single output register while out_ready allows;
// an item sends its pixels in the window: up to 4 at 8 bits, 2 at 16 bits, 32 at 1 bit.
// A new item is taken when none is held or as the held one's last pixel is registered.
// Reset: asynchronous, active low; depth returns to 8 bits, the window to empty.
module framebuffer_word_to_rgb565 #(
	parameter int MAX_LINE_PIXELS = fbw_pkg::MAX_LINE_PIXELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fbw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fbw_pkg::WORD_W-1:0]     source_word,
	input  logic [fbw_pkg::PX_W-1:0]       word_first_x,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fbw_pkg::COLOR_W-1:0]    pixel_color,
	output logic [fbw_pkg::PX_W-1:0]       pixel_x,
	output logic                           last_of_word
);
	import fbw_pkg::*;

	logic [DEPTH_W-1:0] depth_q;
	logic [PX_W-1:0]    left_q;
	logic [RIGHT_W-1:0] right_q;
	lane_res_t          lane_res [LANES];
	logic               take_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = take_ok;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_8;
			left_q  <= '0;
			right_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEPTH: depth_q <= cfg_data[DEPTH_W-1:0];
				REG_LEFT:  left_q  <= cfg_data[PX_W-1:0];
				REG_RIGHT: right_q <= cfg_data[RIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// One lane per possible pixel position in the word.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		fbw_lane #(
			.LANE_IDX        (g),
			.MAX_LINE_PIXELS (MAX_LINE_PIXELS)
		) u_lane (
			.depth        (depth_q),
			.word         (source_word),
			.first_x      (word_first_x),
			.window_left  (left_q),
			.window_right (right_q),
			.res          (lane_res[g])
		);
	end

	// Merge the lane results into an ordered pixel stream.
	fbw_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_valid && take_ok),
		.res          (lane_res),
		.first_x      (word_first_x),
		.take_ok      (take_ok),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_color  (pixel_color),
		.pixel_x      (pixel_x),
		.last_of_word (last_of_word)
	);

endmodule

// ----- rtl/fbw_lane.sv -----
// One pixel lane: extracts its pixel, converts it and checks its column against the window.
module fbw_lane #(
	parameter int LANE_IDX        = 0,
	parameter int MAX_LINE_PIXELS = fbw_pkg::MAX_LINE_PIXELS_DEF
) (
	input  logic [fbw_pkg::DEPTH_W-1:0] depth,
	input  logic [fbw_pkg::WORD_W-1:0]  word,
	input  logic [fbw_pkg::PX_W-1:0]    first_x,
	input  logic [fbw_pkg::PX_W-1:0]    window_left,
	input  logic [fbw_pkg::RIGHT_W-1:0] window_right,
	output fbw_pkg::lane_res_t          res
);
	import fbw_pkg::*;

	// Bit positions of this lane's pixel at each depth.
	localparam int BIT_POS  = WORD_W - 1 - LANE_IDX;
	localparam int BYTE_TOP = WORD_W - 1 - 8 * (LANE_IDX % 4);
	localparam int HALF_TOP = WORD_W - 1 - 16 * (LANE_IDX % 2);
	localparam bit IN_BYTE  = (LANE_IDX < 4);
	localparam bit IN_HALF  = (LANE_IDX < 2);

	logic [XW-1:0]      x;
	logic               in_win;
	logic               active;
	logic [COLOR_W-1:0] color;

	// Column of this pixel and the window test.
	assign x      = XW'(first_x) + XW'(LANE_IDX);
	assign in_win = (x >= {1'b0, window_left}) && (x < window_right) &&
	                ({1'b0, x} < LIM_W'(MAX_LINE_PIXELS));

	// Pixel extraction and colour conversion for the configured depth.
	always_comb begin
		unique case (depth)
			DEPTH_1: begin
				active = 1'b1;
				color  = word[BIT_POS] ? COLOR_BLACK : COLOR_WHITE;
			end
			DEPTH_8: begin
				active = IN_BYTE;
				color  = expand_332(word[BYTE_TOP -: 8]);
			end
			DEPTH_16: begin
				active = IN_HALF;
				color  = remap_555(word[HALF_TOP -: 16]);
			end
			default: begin
				active = 1'b0;
				color  = '0;
			end
		endcase
	end

	assign res.valid = active && in_win;
	assign res.color = color;

endmodule

// ----- rtl/fbw_merge.sv -----
// Merging stage: holds one item's lane results; sends one pixel per cycle unless stalled.
module fbw_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  fbw_pkg::lane_res_t           res [fbw_pkg::LANES],
	input  logic [fbw_pkg::PX_W-1:0]     first_x,
	output logic                         take_ok,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fbw_pkg::COLOR_W-1:0]  pixel_color,
	output logic [fbw_pkg::PX_W-1:0]     pixel_x,
	output logic                         last_of_word
);
	import fbw_pkg::*;

	logic [LANES-1:0]   mask_s1;
	logic [COLOR_W-1:0] color_s1 [LANES];
	logic [PX_W-1:0]    first_x_s1;

	logic [LANES-1:0]   new_mask;
	logic [LANES-1:0]   mask_after;
	logic [LANE_IW-1:0] sel;
	logic               emit;

	logic               out_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic [PX_W-1:0]    x_q;
	logic               last_q;

	// Gather the lane valid bits into a mask.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			new_mask[i] = res[i].valid;
		end
	end

	// Pick the leftmost remaining pixel, which is the lowest set lane.
	always_comb begin
		sel = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (mask_s1[i]) begin
				sel = LANE_IW'(i);
			end
		end
	end

	assign mask_after = mask_s1 & (mask_s1 - LANES'(1));
	assign emit       = (mask_s1 != '0) && (!out_valid_q || out_ready);
	assign take_ok    = (mask_s1 == '0) || (emit && (mask_after == '0));

	// Pending pixel mask of the item in hand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (load) begin
			mask_s1 <= new_mask;
		end else if (emit) begin
			mask_s1 <= mask_after;
		end
	end

	// Colours and first column of the item in hand.
	always_ff @(posedge clk) begin
		if (load) begin
			first_x_s1 <= first_x;
			for (int i = 0; i < LANES; i++) begin
				color_s1[i] <= res[i].color;
			end
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			color_q <= color_s1[sel];
			x_q     <= first_x_s1 + PX_W'(sel);
			last_q  <= (mask_after == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_color  = color_q;
	assign pixel_x      = x_q;
	assign last_of_word = last_q;

endmodule

// ----- rtl/fbw_checker.sv -----
// Port-level checker for the framebuffer word converter, bound to the top level.
module fbw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [fbw_pkg::COLOR_W-1:0] pixel_color,
	input logic [fbw_pkg::PX_W-1:0]    pixel_x,
	input logic                        last_of_word
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_color) &&
		$stable(pixel_x) && $stable(last_of_word))
		else $error("result changed while stalled");

	// Input back-pressure only while an item still has pixels to send.
	a_busy_emits: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("input stalled with no result following");

	// Pixels of one item follow each other without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_word |=> out_valid)
		else $error("gap inside the pixels of one item");

endmodule

bind framebuffer_word_to_rgb565 fbw_checker u_fbw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pixel_color  (pixel_color),
	.pixel_x      (pixel_x),
	.last_of_word (last_of_word)
);
